@@ rtl/core/bdq_pkg.sv @@
`timescale 1ns / 1ps

package bdq_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH_HEAD = 3'd0;
  localparam logic [2:0] REQ_PUSH_TAIL = 3'd1;
  localparam logic [2:0] REQ_POP_HEAD  = 3'd2;
  localparam logic [2:0] REQ_POP_TAIL  = 3'd3;
  localparam logic [2:0] REQ_REMOVE_AT = 3'd4;
  localparam logic [2:0] REQ_READ_AT   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  // What a cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

@@ rtl/core/bdq_cell.sv @@
`timescale 1ns / 1ps

// One storage slot of the chain; takes a word from either neighbor or the load bus.
module bdq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  bdq_pkg::cell_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  input  logic [DATA_WIDTH-1:0]  load_i,
  output logic [DATA_WIDTH-1:0]  data_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    unique case (ctrl_i.op)
      bdq_pkg::CELL_FROM_LEFT:  data_d = left_i;
      bdq_pkg::CELL_FROM_RIGHT: data_d = right_i;
      bdq_pkg::CELL_LOAD:       data_d = load_i;
      default:                  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/bounded_double_ended_queue_top.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH words with indexed remove and read.
// Input channel (in_valid_i/in_ready_o) carries one request word: req_type_i,
// value_i (push data) and position_i (0-based index from head).
// Output channel (out_valid_o/out_ready_i) returns one result word per request:
// read_data_o, status_o and fill_count_o (fill after the request).
// Entries live in a row of cells, head in cell 0. A head push shifts every
// cell one step up, a head pop or remove shifts the cells at and above the
// slot one step down; all of this happens in the single accepting cycle.
// Latency: the result is valid the cycle after acceptance.
// Throughput: one request per cycle; the cell row and the result register
// are updated together on acceptance, so requests may arrive back to back.
// If the receiver stalls, the result register holds its word and
// in_ready_o drops until it is taken (a taken result frees the slot in the
// same cycle).
// Reset clears the fill count and the output valid; cell contents are not
// reset and are only read below the fill count.
module bounded_double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] value_i,
  input  logic [3:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [4:0]  fill_count_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare width covers both the 4-bit position and the fill count
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  logic                  in_fire;
  logic                  out_valid_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      count_d;
  logic [CNT_W-1:0]      count_m1;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;

  logic [63:0]           val_wide;
  logic [DATA_WIDTH-1:0] word;

  // Decoded actions of the current request
  logic                  push_head;
  logic                  push_tail;
  logic                  shift_dn;
  logic [CMP_W-1:0]      shift_from;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  logic [1:0]            status_d;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  bdq_pkg::cell_ctrl_t   cell_ctrl [DEPTH];

  logic [DATA_WIDTH-1:0] rd_word;
  logic [63:0]           rd_wide;
  logic [15:0]           cnt_wide;

  logic [31:0]           read_data_q;
  logic [1:0]            status_q;
  logic [4:0]            fill_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign val_wide = 64'(value_i);
  assign word     = val_wide[DATA_WIDTH-1:0];

  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_ok   = (pos_ext < cnt_ext);
  assign count_m1 = count_q - CNT_W'(1);

  // Request decode
  always_comb begin
    push_head  = 1'b0;
    push_tail  = 1'b0;
    shift_dn   = 1'b0;
    shift_from = '0;
    rd_en      = 1'b0;
    rd_idx     = '0;
    status_d   = bdq_pkg::ST_OK;
    count_d    = count_q;
    unique case (req_type_i)
      bdq_pkg::REQ_PUSH_HEAD, bdq_pkg::REQ_PUSH_TAIL: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          push_head = (req_type_i == bdq_pkg::REQ_PUSH_HEAD);
          push_tail = (req_type_i == bdq_pkg::REQ_PUSH_TAIL);
          count_d   = count_q + CNT_W'(1);
        end
      end
      bdq_pkg::REQ_POP_HEAD: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          shift_dn = 1'b1;
          rd_en    = 1'b1;
          count_d  = count_m1;
        end
      end
      bdq_pkg::REQ_POP_TAIL: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_idx  = count_m1[IDX_W-1:0];
          count_d = count_m1;
        end
      end
      bdq_pkg::REQ_REMOVE_AT: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          status_d = bdq_pkg::ST_BAD_POS;
        end else begin
          shift_dn   = 1'b1;
          shift_from = pos_ext;
          rd_en      = 1'b1;
          rd_idx     = pos_ext[IDX_W-1:0];
          count_d    = count_m1;
        end
      end
      bdq_pkg::REQ_READ_AT: begin
        if (!pos_ok) begin
          status_d = bdq_pkg::ST_BAD_POS;
        end else begin
          rd_en  = 1'b1;
          rd_idx = pos_ext[IDX_W-1:0];
        end
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    // Top cell shifting down keeps its own word (that slot is past the fill)
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    always_comb begin
      cell_ctrl[i].op = bdq_pkg::CELL_HOLD;
      if (in_fire) begin
        if (push_head) begin
          cell_ctrl[i].op = (i == 0) ? bdq_pkg::CELL_LOAD : bdq_pkg::CELL_FROM_LEFT;
        end else if (push_tail && (CNT_W'(i) == count_q)) begin
          cell_ctrl[i].op = bdq_pkg::CELL_LOAD;
        end else if (shift_dn && (CMP_W'(i) >= shift_from)) begin
          cell_ctrl[i].op = bdq_pkg::CELL_FROM_RIGHT;
        end
      end
    end

    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .left_i (left_w),
      .right_i(right_w),
      .load_i (word),
      .data_o (cell_data[i])
    );
  end

  // One-hot read select across the row
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_en && (rd_idx == IDX_W'(i))) begin
        rd_word = rd_word | cell_data[i];
      end
    end
  end

  assign rd_wide  = 64'(rd_word);
  assign cnt_wide = 16'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_data_q <= rd_wide[31:0];
      status_q    <= status_d;
      fill_q      <= cnt_wide[4:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

endmodule
